[rtl/bst_pkg.sv]
package bst_pkg;

	localparam int POS_WIDTH    = 16;
	localparam int MAX_NAME_LEN = 255;
	localparam int LEN_W        = $clog2(MAX_NAME_LEN + 1);

	// output queue, depth must be a power of two
	localparam int Q_DEPTH = 4;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_INT  = 2'd1;
	localparam logic [1:0] KIND_NAME = 2'd2;
	localparam logic [1:0] KIND_END  = 2'd3;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_INT  = 2'd1;
	localparam logic [1:0] MODE_NAME = 2'd2;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_UPA  = 8'h41;
	localparam logic [7:0] CH_UPZ  = 8'h5a;
	localparam logic [7:0] CH_USCR = 8'h5f;
	localparam logic [7:0] CH_LOA  = 8'h61;
	localparam logic [7:0] CH_LOZ  = 8'h7a;

	typedef struct packed {
		logic [1:0]  token_kind;
		logic [7:0]  char_code;
		logic [63:0] int_value;
		logic [15:0] name_start;
		logic [7:0]  name_length;
		logic        last;
	} tok_t;

	// up to two tokens produced by one byte transfer
	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LOA) && (c <= CH_LOZ)) || ((c >= CH_UPA) && (c <= CH_UPZ))
			|| (c == CH_USCR);
	endfunction

endpackage

[rtl/bst_byte_if.sv]
interface bst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

[rtl/bst_token_if.sv]
interface bst_token_if;
	logic        valid;
	logic        ready;
	logic [1:0]  token_kind;
	logic [7:0]  char_code;
	logic [63:0] int_value;
	logic [15:0] name_start;
	logic [7:0]  name_length;
	logic        last;

	modport source (output valid, output token_kind, output char_code, output int_value,
		output name_start, output name_length, output last, input ready);
	modport sink (input valid, input token_kind, input char_code, input int_value,
		input name_start, input name_length, input last, output ready);
endinterface

[rtl/bst_lex.sv]
module bst_lex (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           xfer,
	input  logic [7:0]     char_byte,
	output bst_pkg::push_t push
);
	import bst_pkg::*;

	logic [1:0]           mode_q, mode_d;
	logic [63:0]          acc_q, acc_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d;
	logic [POS_WIDTH-1:0] start_q, start_d;
	logic [LEN_W-1:0]     len_q, len_d;

	logic dig, alp;
	logic run_v, trail_v, cont;
	tok_t run_tok, trail_tok;
	logic [63:0] digit;

	always_comb begin
		dig   = is_digit(char_byte);
		alp   = is_alpha(char_byte);
		digit = 64'(char_byte - CH_0);
		mode_d  = mode_q;
		acc_d   = acc_q;
		pos_d   = pos_q;
		start_d = start_q;
		len_d   = len_q;
		run_v   = 1'b0;
		trail_v = 1'b0;
		cont    = 1'b1;
		run_tok   = '0;
		trail_tok = '0;

		case (mode_q)
			MODE_INT: begin
				if (dig) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + digit;
					pos_d = pos_q + POS_WIDTH'(1);
					cont  = 1'b0;
				end else begin
					run_v = 1'b1;
					run_tok.token_kind = KIND_INT;
					run_tok.int_value  = acc_q;
				end
			end
			MODE_NAME: begin
				if (dig || alp) begin
					if (len_q < LEN_W'(MAX_NAME_LEN))
						len_d = len_q + LEN_W'(1);
					pos_d = pos_q + POS_WIDTH'(1);
					cont  = 1'b0;
				end else begin
					run_v = 1'b1;
					run_tok.token_kind  = KIND_NAME;
					run_tok.name_start  = 16'(start_q);
					run_tok.name_length = 8'(len_q);
				end
			end
			default: ;
		endcase

		if (cont) begin
			mode_d = MODE_IDLE;
			if (char_byte == CH_NUL) begin
				trail_v = 1'b1;
				trail_tok.token_kind = KIND_END;
				pos_d = '0;
				acc_d = '0;
				len_d = '0;
			end else if (dig) begin
				mode_d = MODE_INT;
				acc_d  = digit;
				pos_d  = pos_q + POS_WIDTH'(1);
			end else if (alp) begin
				mode_d  = MODE_NAME;
				start_d = pos_q;
				len_d   = LEN_W'(1);
				pos_d   = pos_q + POS_WIDTH'(1);
			end else begin
				trail_v = 1'b1;
				trail_tok.token_kind = KIND_CHAR;
				trail_tok.char_code  = char_byte;
				pos_d = pos_q + POS_WIDTH'(1);
			end
		end

		run_tok.last   = !trail_v;
		trail_tok.last = 1'b1;

		push.n  = xfer ? (2'(run_v) + 2'(trail_v)) : 2'd0;
		push.t0 = run_v ? run_tok : trail_tok;
		push.t1 = trail_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
		end else if (xfer) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
		end
	end

	a_nul_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && char_byte == CH_NUL) |=> (pos_q == '0 && mode_q == MODE_IDLE))
		else $error("position not cleared after end of text");
	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (!push.t0.last && push.t1.last))
		else $error("bad last marking on paired tokens");
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!xfer |=> ($stable(mode_q) && $stable(pos_q)))
		else $error("scan state changed without a transfer");
endmodule

[rtl/bst_outq.sv]
module bst_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  bst_pkg::push_t   push,
	output logic             room,
	bst_token_if.source      tokens
);
	import bst_pkg::*;

	tok_t             mem [Q_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	tok_t             head;

	assign pop  = tokens.valid && tokens.ready;
	assign room = cnt_q <= CNT_W'(Q_DEPTH - 2);
	assign head = mem[rp_q];

	assign tokens.valid       = cnt_q != '0;
	assign tokens.token_kind  = head.token_kind;
	assign tokens.char_code   = head.char_code;
	assign tokens.int_value   = head.int_value;
	assign tokens.name_start  = head.name_start;
	assign tokens.name_length = head.name_length;
	assign tokens.last        = head.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wp_q] <= push.t0;
		if (push.n == 2'd2)
			mem[wp_q + PTR_W'(1)] <= push.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push.n);
			if (pop)
				rp_q <= rp_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> (CNT_W'(cnt_q + CNT_W'(push.n) - CNT_W'(pop))
			<= CNT_W'(Q_DEPTH) && cnt_q + CNT_W'(push.n) >= CNT_W'(push.n)))
		else $error("output queue overflow");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(Q_DEPTH))
		else $error("queue count out of range");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.n == 2'd0) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("queue count did not drop on transfer");
endmodule

[rtl/byte_stream_tokenizer.sv]
// channel  role    payload
// text     sink    char_byte[7:0]
// tokens   source  token_kind[1:0] char_code[7:0] int_value[63:0]
//                  name_start[15:0] name_length[7:0] last
//
// One byte per cycle: the scanner updates its state in the cycle of the transfer and
// writes zero, one or two tokens into a four-entry output queue.
// Tokens leave the queue one per cycle; a byte is taken while two entries are free.
// Reset clears the scan state and empties the queue; no clearing pass.
// A stalled token output fills the queue past two entries and then holds text.ready low.
module byte_stream_tokenizer (
	input logic         clk,
	input logic         arst_n,
	bst_byte_if.sink    text,
	bst_token_if.source tokens
);
	import bst_pkg::*;

	push_t push;
	logic  room;
	logic  xfer;

	assign text.ready = room;
	assign xfer       = text.valid && room;

	bst_lex u_lex (
		.clk       (clk),
		.arst_n    (arst_n),
		.xfer      (xfer),
		.char_byte (text.char_byte),
		.push      (push)
	);

	bst_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tokens (tokens)
	);
endmodule

[tb/tokenizer_checker.sv]
`timescale 1ns / 1ps
module tokenizer_checker
	import bst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic [7:0]  char_byte,
	input  logic        tok_valid,
	input  logic        tok_ready,
	input  logic [1:0]  token_kind,
	input  logic [7:0]  char_code,
	input  logic [63:0] int_value,
	input  logic [15:0] name_start,
	input  logic [7:0]  name_length,
	input  logic        last,
	output int          token_errors,
	output int          tokens_owed
);

	logic [1:0]           mode;
	logic [63:0]          acc;
	logic [POS_WIDTH-1:0] pos;
	logic [POS_WIDTH-1:0] name_pos;
	logic [LEN_W-1:0]     name_len;
	tok_t                 pending_tokens[$];
	tok_t                 got;

	function automatic logic dec_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic ident_letter(input logic [7:0] c);
		return c == CH_USCR || (c >= CH_UPA && c <= CH_UPZ) || (c >= CH_LOA && c <= CH_LOZ);
	endfunction

	function automatic tok_t make_token(input logic [1:0] kind, input logic [7:0] ch,
		input logic [63:0] ival, input logic [POS_WIDTH-1:0] start, input logic [LEN_W-1:0] len);
		tok_t t;
		t = '0;
		t.token_kind  = kind;
		t.char_code   = ch;
		t.int_value   = ival;
		t.name_start  = start;
		t.name_length = len;
		return t;
	endfunction

	function automatic string token_text(input tok_t t);
		return $sformatf("kind=%0d char=%02h int=%0d start=%0d len=%0d last=%0d",
			t.token_kind, t.char_code, t.int_value, t.name_start, t.name_length, t.last);
	endfunction

	// one byte in, zero to two tokens out
	task automatic tokenize_byte(input logic [7:0] c);
		tok_t produced[2];
		int   n;
		bit   absorbed;
		n = 0;
		absorbed = 1'b0;
		case (mode)
		MODE_INT: begin
			if (dec_digit(c)) begin
				acc = acc * 64'd10 + 64'(c - CH_0);
				pos++;
				absorbed = 1'b1;
			end else begin
				produced[n] = make_token(KIND_INT, '0, acc, '0, '0);
				n++;
				mode = MODE_IDLE;
			end
		end
		MODE_NAME: begin
			if (ident_letter(c) || dec_digit(c)) begin
				if (name_len < MAX_NAME_LEN)
					name_len++;
				pos++;
				absorbed = 1'b1;
			end else begin
				produced[n] = make_token(KIND_NAME, '0, '0, name_pos, name_len);
				n++;
				mode = MODE_IDLE;
			end
		end
		default: mode = MODE_IDLE;
		endcase
		if (!absorbed) begin
			if (c == CH_NUL) begin
				produced[n] = make_token(KIND_END, '0, '0, '0, '0);
				n++;
				pos = '0;
				acc = '0;
				name_len = '0;
			end else if (dec_digit(c)) begin
				mode = MODE_INT;
				acc = 64'(c - CH_0);
				pos++;
			end else if (ident_letter(c)) begin
				mode = MODE_NAME;
				name_pos = pos;
				name_len = LEN_W'(1);
				pos++;
			end else begin
				produced[n] = make_token(KIND_CHAR, c, '0, '0, '0);
				n++;
				pos++;
			end
		end
		for (int i = 0; i < n; i++) begin
			produced[i].last = (i == n - 1);
			pending_tokens.push_back(produced[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_IDLE;
			acc = '0;
			pos = '0;
			name_pos = '0;
			name_len = '0;
			pending_tokens.delete();
			token_errors = 0;
			tokens_owed = 0;
		end else begin
			if (tok_valid && tok_ready) begin
				got = {token_kind, char_code, int_value, name_start, name_length, last};
				if (pending_tokens.size() == 0) begin
					token_errors++;
					$display("%0t: token mismatch: expected none, got %s", $time,
						token_text(got));
				end else begin
					if (got !== pending_tokens[0]) begin
						token_errors++;
						$display("%0t: token mismatch: expected %s, got %s", $time,
							token_text(pending_tokens[0]), token_text(got));
					end
					void'(pending_tokens.pop_front());
				end
			end
			if (byte_valid && byte_ready)
				tokenize_byte(char_byte);
			tokens_owed = pending_tokens.size();
		end
	end

endmodule

[tb/tb_byte_stream_tokenizer.sv]
`timescale 1ns / 1ps
module tb_byte_stream_tokenizer;
	import bst_pkg::*;

	localparam int HALF_PERIOD = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   token_errors;
	int   tokens_owed;
	bit   tx_steady;
	bit   rx_steady;
	int   rx_hold;

	bst_byte_if  text_if();
	bst_token_if tok_if();

	byte_stream_tokenizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.tokens (tok_if)
	);

	tokenizer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (text_if.valid),
		.byte_ready   (text_if.ready),
		.char_byte    (text_if.char_byte),
		.tok_valid    (tok_if.valid),
		.tok_ready    (tok_if.ready),
		.token_kind   (tok_if.token_kind),
		.char_code    (tok_if.char_code),
		.int_value    (tok_if.int_value),
		.name_start   (tok_if.name_start),
		.name_length  (tok_if.name_length),
		.last         (tok_if.last),
		.token_errors (token_errors),
		.tokens_owed  (tokens_owed)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		#(1_000_000 * 2 * HALF_PERIOD);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [7:0] ident_char(input bit allow_digit);
		int n;
		n = allow_digit ? $urandom_range(0, 62) : $urandom_range(0, 52);
		if (n < 26)
			return 8'(CH_LOA + n);
		else if (n < 52)
			return 8'(CH_UPA + n - 26);
		else if (n == 52)
			return CH_USCR;
		return 8'(CH_0 + n - 53);
	endfunction

	function automatic logic [7:0] other_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (is_digit(c) || is_alpha(c));
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] c);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			text_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.char_byte <= c;
		do @(posedge clk); while (!text_if.ready);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		text_if.valid <= 1'b0;
		while (tokens_owed != 0)
			@(negedge clk);
	endtask

	// mostly well-formed names, numbers and separators, plus some noise
	task automatic send_segment(input bit allow_nul, inout int sent);
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		case (kind)
		0, 1, 2: begin
			len = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 10);
			send_byte(ident_char(1'b0));
			for (int i = 1; i < len; i++)
				send_byte(ident_char(1'b1));
		end
		3, 4: begin
			len = $urandom_range(1, 22);
			for (int i = 0; i < len; i++)
				send_byte(8'(CH_0 + $urandom_range(0, 9)));
		end
		5, 6: begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				send_byte(other_char());
		end
		7: begin
			len = 1;
			send_byte(8'($urandom_range(128, 255)));
		end
		8: begin
			len = 1;
			send_byte(allow_nul ? CH_NUL : other_char());
		end
		default: begin
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(allow_nul ? 0 : 1, 255)));
		end
		endcase
		sent += len;
	endtask

	initial begin : token_sink
		int stall;
		tok_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 17);
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				tok_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			tok_if.ready <= 1'b1;
			do @(posedge clk); while (!tok_if.valid);
			@(negedge clk);
		end
	end

	initial begin : byte_source
		logic [7:0] edge_bytes[$];
		int         sent;
		text_if.valid = 1'b0;
		text_if.char_byte = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// class boundaries, high bytes, end of text with and without a pending run
		edge_bytes = {CH_UPA, CH_UPZ, CH_LOA, CH_LOZ, CH_USCR, CH_0, 8'h2f, CH_9, CH_0,
			8'h3a, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h20, 8'h7f, 8'h80, 8'hff, 8'h37, CH_NUL,
			8'h71, CH_NUL, CH_NUL, 8'h35, 8'h78};
		foreach (edge_bytes[i])
			send_byte(edge_bytes[i]);
		send_byte(CH_NUL);
		wait_drained();

		// 64-bit wrap of integers, name length saturation
		send_text("18446744073709551615 18446744073709551616,");
		for (int i = 0; i < 25; i++)
			send_byte(8'(CH_0 + $urandom_range(0, 9)));
		send_byte(8'h20);
		send_byte(ident_char(1'b0));
		for (int i = 0; i < 299; i++)
			send_byte(ident_char(1'b1));
		send_byte(8'h3b);
		send_byte(CH_NUL);
		wait_drained();

		// long output stall while input keeps coming
		tx_steady = 1'b1;
		rx_hold = 300;
		for (int i = 0; i < 40; i++)
			send_byte((i % 7 == 3) ? ident_char(1'b0) : other_char());
		tx_steady = 1'b0;
		wait_drained();

		sent = 0;
		while (sent < 1100) begin
			if ($urandom_range(0, 5) == 0)
				tx_steady = !tx_steady;
			if ($urandom_range(0, 5) == 0)
				rx_steady = !rx_steady;
			send_segment(1'b1, sent);
		end
		send_byte(CH_NUL);
		wait_drained();
		repeat (20) @(negedge clk);

		if (token_errors == 0 && tokens_owed == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[byte_stream_tokenizer.f]
rtl/bst_pkg.sv
rtl/bst_byte_if.sv
rtl/bst_token_if.sv
rtl/bst_lex.sv
rtl/bst_outq.sv
rtl/byte_stream_tokenizer.sv
tb/tokenizer_checker.sv
tb/tb_byte_stream_tokenizer.sv
